/* hdl/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg: shared definitions of the phase sequence timer
// Widths, reset values, codes, phase table and the state/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

	localparam int SEQ_LEN   = 10;
	localparam int POS_W     = 4;
	localparam int TICK_W    = 16;
	localparam int BLINK_W   = 8;
	localparam int MODE_W    = 2;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SEQ_LEN - 1);

	// run modes / button codes
	localparam logic [MODE_W-1:0] CODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

	// phase kinds
	localparam logic [1:0] KIND_WORK  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_WORK  = 2'd0;
	localparam logic [1:0] REG_SHORT = 2'd1;
	localparam logic [1:0] REG_LONG  = 2'd2;
	localparam logic [1:0] REG_BLINK = 2'd3;

	localparam logic [TICK_W-1:0]  WORK_RST  = 16'd100;
	localparam logic [TICK_W-1:0]  SHORT_RST = 16'd25;
	localparam logic [TICK_W-1:0]  LONG_RST  = 16'd150;
	localparam logic [BLINK_W-1:0] BLINK_RST = 8'd4;

	typedef struct packed {
		logic [TICK_W-1:0]  work_ticks;
		logic [TICK_W-1:0]  short_break_ticks;
		logic [TICK_W-1:0]  long_break_ticks;
		logic [BLINK_W-1:0] blink_ticks;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [TICK_W-1:0]  phase_left;
		logic [MODE_W-1:0]  mode;
		logic [MODE_W-1:0]  prev_code;
		logic [BLINK_W-1:0] blink_left;
		logic               lamp;
	} state_t;

	typedef struct packed {
		logic               indicator_on;
		logic               red_on;
		logic               green_on;
		logic               blue_on;
		logic [POS_W-1:0]   phase_position;
		logic [TICK_W-1:0]  ticks_left;
		logic [MODE_W-1:0]  mode_now;
	} result_t;

	// even positions work, odd short break, last long break
	function automatic logic [1:0] phase_kind(input logic [POS_W-1:0] pos);
		if (pos == LAST_POS)
			return KIND_LONG;
		return pos[0] ? KIND_SHORT : KIND_WORK;
	endfunction

endpackage

`default_nettype wire

/* hdl/pst_if.sv */
// ----------------------------------------------------------------------------
// pst_if: tick and result channels
// Valid/ready channels carrying one tick of button levels and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_tick_if;
	logic valid;
	logic ready;
	logic play_pressed;
	logic pause_pressed;
	logic stop_pressed;

	modport source (output valid, play_pressed, pause_pressed, stop_pressed, input ready);
	modport sink   (input valid, play_pressed, pause_pressed, stop_pressed, output ready);
endinterface

interface pst_result_if;
	logic                         valid;
	logic                         ready;
	logic                         indicator_on;
	logic                         red_on;
	logic                         green_on;
	logic                         blue_on;
	logic [pst_pkg::POS_W-1:0]    phase_position;
	logic [pst_pkg::TICK_W-1:0]   ticks_left;
	logic [pst_pkg::MODE_W-1:0]   mode_now;

	modport source (output valid, indicator_on, red_on, green_on, blue_on, phase_position,
		ticks_left, mode_now, input ready);
	modport sink   (input valid, indicator_on, red_on, green_on, blue_on, phase_position,
		ticks_left, mode_now, output ready);
endinterface

`default_nettype wire

/* hdl/phase_sequence_timer.sv */
// Path: an accepted tick is held in the input register, then in the result
//   register, where it stays while the result is stalled.
// Throughput: one tick per cycle while the result is not stalled; the phase/blink/mode state is updated in the
//   single cycle in which a tick moves from the input register to the result.
// Reset: arst_n clears all control state asynchronously and loads the register
//   defaults (work 100, short 25, long 150, blink 4) and the matching state.
// ----------------------------------------------------------------------------
// phase_sequence_timer: cyclic work / break phase timer
// One result transaction per tick, with APB configuration of the durations.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_sequence_timer (
	input  wire                          clk,
	input  wire                          arst_n,
	pst_tick_if.sink                     tick,
	pst_result_if.source                 result,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [pst_pkg::APB_AW-1:0]   paddr,
	input  wire  [pst_pkg::APB_DW-1:0]   pwdata,
	output logic [pst_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	// configuration registers
	pst_pkg::cfg_t    cfg_q;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	// timer state
	pst_pkg::state_t  state_q;
	pst_pkg::state_t  state_nxt;
	pst_pkg::result_t res_nxt;

	// input stage: the buttons of an accepted tick
	logic             valid_s1;
	logic             play_s1;
	logic             pause_s1;
	logic             stop_s1;

	// result register
	logic             res_valid_q;
	pst_pkg::result_t res_q;

	logic             advance;

	// --- APB: always ready, register i at byte 4*i ---
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work_ticks        <= pst_pkg::WORK_RST;
			cfg_q.short_break_ticks <= pst_pkg::SHORT_RST;
			cfg_q.long_break_ticks  <= pst_pkg::LONG_RST;
			cfg_q.blink_ticks       <= pst_pkg::BLINK_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				pst_pkg::REG_WORK:  cfg_q.work_ticks        <= pwdata[15:0];
				pst_pkg::REG_SHORT: cfg_q.short_break_ticks <= pwdata[15:0];
				pst_pkg::REG_LONG:  cfg_q.long_break_ticks  <= pwdata[15:0];
				pst_pkg::REG_BLINK: cfg_q.blink_ticks       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pst_pkg::REG_WORK:  prdata = {16'd0, cfg_q.work_ticks};
			pst_pkg::REG_SHORT: prdata = {16'd0, cfg_q.short_break_ticks};
			pst_pkg::REG_LONG:  prdata = {16'd0, cfg_q.long_break_ticks};
			pst_pkg::REG_BLINK: prdata = {24'd0, cfg_q.blink_ticks};
			default:            prdata = '0;
		endcase
	end

	// --- flow control ---
	// The tick in the input stage moves on whenever the result register is
	// empty or being emptied; the input stage refills in the same cycle.
	assign advance     = !res_valid_q || result.ready;
	assign tick.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			play_s1  <= tick.play_pressed;
			pause_s1 <= tick.pause_pressed;
			stop_s1  <= tick.stop_pressed;
		end
	end

	// --- per-tick update ---
	pst_step u_step (
		.cur   (state_q),
		.cfg   (cfg_q),
		.play  (play_s1),
		.pause (pause_s1),
		.stop  (stop_s1),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pos        <= '0;
			state_q.phase_left <= pst_pkg::WORK_RST;
			state_q.mode       <= pst_pkg::MODE_PLAY;
			state_q.prev_code  <= pst_pkg::CODE_NONE;
			state_q.blink_left <= pst_pkg::BLINK_RST;
			state_q.lamp       <= 1'b1;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_q <= res_nxt;
	end

	assign result.valid          = res_valid_q;
	assign result.indicator_on   = res_q.indicator_on;
	assign result.red_on         = res_q.red_on;
	assign result.green_on       = res_q.green_on;
	assign result.blue_on        = res_q.blue_on;
	assign result.phase_position = res_q.phase_position;
	assign result.ticks_left     = res_q.ticks_left;
	assign result.mode_now       = res_q.mode_now;

endmodule

`default_nettype wire

/* hdl/pst_step.sv */
// ----------------------------------------------------------------------------
// pst_step: next-state logic for one tick
// Applies the run mode, blink reload, phase advance and button filter.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_step (
	input  wire  pst_pkg::state_t  cur,
	input  wire  pst_pkg::cfg_t    cfg,
	input  wire                    play,
	input  wire                    pause,
	input  wire                    stop,
	output pst_pkg::state_t        nxt,
	output pst_pkg::result_t       res
);

	logic [pst_pkg::MODE_W-1:0] code;
	logic [1:0]                 kind;
	logic [1:0]                 new_kind;

	always_comb begin
		nxt = cur;

		case (cur.mode)
			pst_pkg::MODE_PLAY: begin
				if (cur.phase_left != '0)
					nxt.phase_left = cur.phase_left - 1'b1;
				nxt.blink_left = cfg.blink_ticks;
				nxt.lamp       = 1'b1;
			end
			pst_pkg::MODE_PAUSE: begin
				if (cur.blink_left != '0)
					nxt.blink_left = cur.blink_left - 1'b1;
			end
			pst_pkg::MODE_STOP: begin
				nxt.phase_left = '0;
				nxt.mode       = pst_pkg::MODE_PLAY;
			end
			default: ;
		endcase

		if (nxt.blink_left == '0) begin
			nxt.lamp       = ~nxt.lamp;
			nxt.blink_left = cfg.blink_ticks;
		end

		new_kind = pst_pkg::KIND_WORK;
		if (nxt.phase_left == '0) begin
			nxt.pos  = (cur.pos == pst_pkg::LAST_POS) ? '0 : cur.pos + 1'b1;
			new_kind = pst_pkg::phase_kind(nxt.pos);
			case (new_kind)
				pst_pkg::KIND_WORK:  nxt.phase_left = cfg.work_ticks;
				pst_pkg::KIND_SHORT: nxt.phase_left = cfg.short_break_ticks;
				default:             nxt.phase_left = cfg.long_break_ticks;
			endcase
		end

		// one button alone gives a code, anything else is none
		case ({play, pause, stop})
			3'b100:  code = pst_pkg::MODE_PLAY;
			3'b010:  code = pst_pkg::MODE_PAUSE;
			3'b001:  code = pst_pkg::MODE_STOP;
			default: code = pst_pkg::CODE_NONE;
		endcase
		if (code != pst_pkg::CODE_NONE && code != cur.prev_code)
			nxt.mode = code;
		nxt.prev_code = code;

		kind               = pst_pkg::phase_kind(nxt.pos);
		res.indicator_on   = nxt.lamp;
		res.red_on         = (kind == pst_pkg::KIND_WORK);
		res.green_on       = (kind == pst_pkg::KIND_SHORT);
		res.blue_on        = (kind == pst_pkg::KIND_LONG);
		res.phase_position = nxt.pos;
		res.ticks_left     = nxt.phase_left;
		res.mode_now       = nxt.mode;
	end

endmodule

`default_nettype wire

/* hdl/pst_checker.sv */
// ----------------------------------------------------------------------------
// pst_checker: port-level checks of the phase sequence timer
// Result hold under stall and consistency of colour, position and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          res_valid,
	input wire                          res_ready,
	input wire                          red_on,
	input wire                          green_on,
	input wire                          blue_on,
	input wire [pst_pkg::POS_W-1:0]     phase_position,
	input wire [pst_pkg::TICK_W-1:0]    ticks_left,
	input wire [pst_pkg::MODE_W-1:0]    mode_now
);

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(ticks_left)
			&& $stable(phase_position) && $stable(mode_now))
		else $error("result changed while stalled");

	ap_colour: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot({red_on, green_on, blue_on}))
		else $error("colour not one-hot");

	ap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> phase_position <= pst_pkg::LAST_POS)
		else $error("phase position out of range");

	ap_long: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> blue_on == (phase_position == pst_pkg::LAST_POS)
			&& red_on == (!blue_on && !phase_position[0]))
		else $error("colour does not match position");

	ap_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> mode_now != pst_pkg::CODE_NONE)
		else $error("run mode is zero");

endmodule

bind phase_sequence_timer pst_checker u_pst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.red_on         (result.red_on),
	.green_on       (result.green_on),
	.blue_on        (result.blue_on),
	.phase_position (result.phase_position),
	.ticks_left     (result.ticks_left),
	.mode_now       (result.mode_now)
);

`default_nettype wire
